### sv/assert_macros.svh
// Assertion helpers shared by the RTL modules.
// Both sample on the rising edge of clk and are switched off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A condition that must be followed by another in the next cycle.
`define ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

### sv/bvm_pkg.sv
package bvm_pkg;

	// Fixed geometry of the machine.
	localparam int MEM_BYTES       = 4096;
	localparam int ADDR_W          = 12;
	localparam int STACK_DEPTH_DEF = 16;
	localparam int SCREEN_WIDTH    = 64;
	localparam int SCREEN_HEIGHT   = 32;
	localparam int COL_W           = 6;
	localparam int ROW_W           = 5;

	localparam logic [11:0] PC_START = 12'h200;

	// Item operations.
	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_EXEC  = 2'd1,
		OP_PIXEL = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	// Instruction major opcodes.
	localparam logic [3:0] OPC_SYS  = 4'h0;
	localparam logic [3:0] OPC_JP   = 4'h1;
	localparam logic [3:0] OPC_CALL = 4'h2;
	localparam logic [3:0] OPC_SEI  = 4'h3;
	localparam logic [3:0] OPC_SNEI = 4'h4;
	localparam logic [3:0] OPC_SER  = 4'h5;
	localparam logic [3:0] OPC_LDI  = 4'h6;
	localparam logic [3:0] OPC_ADDI = 4'h7;
	localparam logic [3:0] OPC_ALU  = 4'h8;
	localparam logic [3:0] OPC_SNER = 4'h9;
	localparam logic [3:0] OPC_LDIX = 4'hA;
	localparam logic [3:0] OPC_JPV0 = 4'hB;
	localparam logic [3:0] OPC_RND  = 4'hC;
	localparam logic [3:0] OPC_DRW  = 4'hD;
	localparam logic [3:0] OPC_KEY  = 4'hE;
	localparam logic [3:0] OPC_MISC = 4'hF;

	localparam logic [11:0] SYS_CLS = 12'h0E0;
	localparam logic [11:0] SYS_RET = 12'h0EE;

	// ALU sub-operations.
	localparam logic [3:0] ALU_MOV  = 4'h0;
	localparam logic [3:0] ALU_OR   = 4'h1;
	localparam logic [3:0] ALU_AND  = 4'h2;
	localparam logic [3:0] ALU_XOR  = 4'h3;
	localparam logic [3:0] ALU_ADD  = 4'h4;
	localparam logic [3:0] ALU_SUB  = 4'h5;
	localparam logic [3:0] ALU_SHR  = 4'h6;
	localparam logic [3:0] ALU_SUBN = 4'h7;
	localparam logic [3:0] ALU_SHL  = 4'hE;

	// Key and miscellaneous sub-operations.
	localparam logic [7:0] KEY_DOWN = 8'h9E;
	localparam logic [7:0] KEY_UP   = 8'hA1;
	localparam logic [7:0] MISC_GDT = 8'h07;
	localparam logic [7:0] MISC_WK  = 8'h0A;
	localparam logic [7:0] MISC_SDT = 8'h15;
	localparam logic [7:0] MISC_SST = 8'h18;
	localparam logic [7:0] MISC_ADI = 8'h1E;
	localparam logic [7:0] MISC_FNT = 8'h29;
	localparam logic [7:0] MISC_BCD = 8'h33;
	localparam logic [7:0] MISC_STR = 8'h55;
	localparam logic [7:0] MISC_LDR = 8'h65;

	// Controller states.
	typedef enum logic [4:0] {
		S_IDLE, S_DISPATCH, S_LOAD, S_PIX0, S_PIX1,
		S_F0, S_F1, S_F2, S_RX, S_RY, S_EXEC, S_FLAG, S_KEY,
		S_DRD, S_DWR, S_B0, S_B1, S_B2, S_SRD, S_SWR, S_LRD, S_LWR, S_DONE
	} state_t;

	// Datapath commands.
	typedef enum logic [4:0] {
		CMD_NONE, CMD_ACCEPT, CMD_LOAD, CMD_PIX_RD, CMD_PIX_GET,
		CMD_FETCH0, CMD_FETCH1, CMD_FETCH2, CMD_RD_X, CMD_RD_Y, CMD_EXEC,
		CMD_FLAG, CMD_KEY, CMD_DRAW_RD, CMD_DRAW_WR, CMD_BCD0, CMD_BCD1,
		CMD_BCD2, CMD_ST_RD, CMD_ST_WR, CMD_LD_RD, CMD_LD_WR
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		op_t  op;
		logic key_wait;
		logic is_draw;
		logic is_flag;
		logic is_bcd;
		logic is_store;
		logic is_load;
		logic draw_end;
		logic loop_last;
	} stat_t;

endpackage

### sv/bytecode_vm_core_with_display.sv
// Channel   Handshake         Payload
// command   start / busy      operation, load_address, load_byte, key_bits,
//                             random_byte, query_column, query_row
// result    done (strobe)     program_counter, pixel_on, sound_active,
//                             frame_changed, waiting_key, stack_fault
//
// One item at a time; busy stays high from acceptance until the result strobe.
// A load passes S_LOAD, a pixel read S_PIX0 and S_PIX1, a key-wait step S_KEY. An
// instruction passes S_F0 to S_F2, S_RX, S_RY and S_EXEC, plus S_FLAG if it writes VF,
// S_B0 to S_B2 for Fx33, S_DRD/S_DWR per drawn sprite row, S_SRD/S_SWR or S_LRD/S_LWR
// per register for Fx55/Fx65. Main memory: one registered byte read per cycle.
// Reset is asynchronous; the frame and data registers read as zero after reset
// through per-row and per-register valid bits, so no clearing pass is needed.
// The result is shown for one cycle only; the receiver cannot stall it.
module bytecode_vm_core_with_display import bvm_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [11:0] load_address,
	input  logic [7:0]  load_byte,
	input  logic [15:0] key_bits,
	input  logic [7:0]  random_byte,
	input  logic [5:0]  query_column,
	input  logic [4:0]  query_row,
	output logic        done,
	output logic [11:0] program_counter,
	output logic        pixel_on,
	output logic        sound_active,
	output logic        frame_changed,
	output logic        waiting_key,
	output logic        stack_fault
);

	cmd_t  cmd;
	stat_t st;

	// Sequencer.
	bvm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// Machine state, memories and execution units.
	bvm_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.operation       (operation),
		.load_address    (load_address),
		.load_byte       (load_byte),
		.key_bits        (key_bits),
		.random_byte     (random_byte),
		.query_column    (query_column),
		.query_row       (query_row),
		.program_counter (program_counter),
		.pixel_on        (pixel_on),
		.sound_active    (sound_active),
		.frame_changed   (frame_changed),
		.waiting_key     (waiting_key),
		.stack_fault     (stack_fault)
	);

endmodule

### sv/bvm_ctrl.sv
`include "assert_macros.svh"

module bvm_ctrl import bvm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  stat_t st,
	output logic  busy,
	output logic  done,
	output cmd_t  cmd
);

	state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				case (st.op)
					OP_LOAD:  state_d = S_LOAD;
					OP_EXEC:  state_d = st.key_wait ? S_KEY : S_F0;
					OP_PIXEL: state_d = S_PIX0;
					default:  state_d = S_DONE;
				endcase
			end
			S_LOAD: state_d = S_DONE;
			S_PIX0: state_d = S_PIX1;
			S_PIX1: state_d = S_DONE;
			S_F0:   state_d = S_F1;
			S_F1:   state_d = S_F2;
			S_F2:   state_d = S_RX;
			S_RX:   state_d = S_RY;
			S_RY:   state_d = S_EXEC;
			S_EXEC: begin
				if (st.is_draw)       state_d = S_DRD;
				else if (st.is_flag)  state_d = S_FLAG;
				else if (st.is_bcd)   state_d = S_B0;
				else if (st.is_store) state_d = S_SRD;
				else if (st.is_load)  state_d = S_LRD;
				else                  state_d = S_DONE;
			end
			S_DRD:  state_d = st.draw_end ? S_FLAG : S_DWR;
			S_DWR:  state_d = S_DRD;
			S_B0:   state_d = S_B1;
			S_B1:   state_d = S_B2;
			S_B2:   state_d = S_DONE;
			S_SRD:  state_d = S_SWR;
			S_SWR:  state_d = st.loop_last ? S_DONE : S_SRD;
			S_LRD:  state_d = S_LWR;
			S_LWR:  state_d = st.loop_last ? S_DONE : S_LRD;
			S_FLAG: state_d = S_DONE;
			S_KEY:  state_d = S_DONE;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Output logic: one datapath command per state.
	always_comb begin
		cmd  = CMD_NONE;
		busy = (state_q != S_IDLE);
		done = (state_q == S_DONE);
		case (state_q)
			S_IDLE:  cmd = start ? CMD_ACCEPT : CMD_NONE;
			S_LOAD:  cmd = CMD_LOAD;
			S_PIX0:  cmd = CMD_PIX_RD;
			S_PIX1:  cmd = CMD_PIX_GET;
			S_F0:    cmd = CMD_FETCH0;
			S_F1:    cmd = CMD_FETCH1;
			S_F2:    cmd = CMD_FETCH2;
			S_RX:    cmd = CMD_RD_X;
			S_RY:    cmd = CMD_RD_Y;
			S_EXEC:  cmd = CMD_EXEC;
			S_FLAG:  cmd = CMD_FLAG;
			S_KEY:   cmd = CMD_KEY;
			S_DRD:   cmd = CMD_DRAW_RD;
			S_DWR:   cmd = CMD_DRAW_WR;
			S_B0:    cmd = CMD_BCD0;
			S_B1:    cmd = CMD_BCD1;
			S_B2:    cmd = CMD_BCD2;
			S_SRD:   cmd = CMD_ST_RD;
			S_SWR:   cmd = CMD_ST_WR;
			S_LRD:   cmd = CMD_LD_RD;
			S_LWR:   cmd = CMD_LD_WR;
			default: cmd = CMD_NONE;
		endcase
	end

	`ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted item did not make the core busy")
	`ASSERT_NEXT(a_done_single, done, !done && !busy, "result strobe longer than one cycle")
	`ASSERT_CLK(a_accept_idle, (cmd == CMD_ACCEPT) == (start && !busy), "accept outside idle")

endmodule

### sv/bvm_dp.sv
`include "assert_macros.svh"

module bvm_dp import bvm_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output stat_t       st,
	input  logic [1:0]  operation,
	input  logic [11:0] load_address,
	input  logic [7:0]  load_byte,
	input  logic [15:0] key_bits,
	input  logic [7:0]  random_byte,
	input  logic [5:0]  query_column,
	input  logic [4:0]  query_row,
	output logic [11:0] program_counter,
	output logic        pixel_on,
	output logic        sound_active,
	output logic        frame_changed,
	output logic        waiting_key,
	output logic        stack_fault
);

	localparam int LW  = $clog2(STACK_DEPTH + 1);
	localparam int SAW = $clog2(STACK_DEPTH);

	// Latched item fields.
	op_t         op_q;
	logic [11:0] addr_q;
	logic [7:0]  byte_q, rnd_q;
	logic [15:0] keys_q;
	logic [5:0]  col_q;
	logic [4:0]  row_q;

	// Architectural state.
	logic [11:0]   pc_q, i_q;
	logic [7:0]    dly_q, snd_q;
	logic          kw_q;
	logic [3:0]    kwreg_q;
	logic [15:0]   base_q;
	logic [LW-1:0] lvl_q;
	logic          pixel_q, changed_q, fault_q;

	// Working registers of the current instruction.
	logic [7:0] hi_q, lo_q, vx_q, vy_q;
	logic       flag_q;
	logic [3:0] cnt_q;

	// Instruction fields.
	logic [3:0]  opc, x, y, n;
	logic [7:0]  nn;
	logic [11:0] nnn;

	assign opc = hi_q[7:4];
	assign x   = hi_q[3:0];
	assign y   = lo_q[7:4];
	assign n   = lo_q[3:0];
	assign nn  = lo_q;
	assign nnn = {hi_q[3:0], lo_q};

	// Main memory: one write and one registered read port.
	logic [7:0]  mem [MEM_BYTES];
	logic        mem_we;
	logic [11:0] mem_wa, mem_ra, mem_off;
	logic [7:0]  mem_wd, mem_rd_q;

	// Data registers: small memory with valid bits so that reset reads as zero.
	logic [7:0]  vmem [16];
	logic [15:0] v_valid_q;
	logic        v_we;
	logic [3:0]  v_wa, v_ra;
	logic [7:0]  v_wd, v_rd_q;

	// Return stack.
	logic [11:0]    stk [STACK_DEPTH];
	logic           stk_we;
	logic [SAW-1:0] stk_ra;
	logic [11:0]    stk_rd_q;

	// Frame: one 64-bit word per row, with a valid bit per row.
	logic [63:0] fmem [SCREEN_HEIGHT];
	logic [31:0] f_valid_q;
	logic        f_we, f_clr;
	logic [4:0]  f_ra, f_wa;
	logic [63:0] f_wd, f_rd_q;

	// Sprite row placement.
	logic [5:0]  draw_row;
	logic [63:0] draw_mask;
	logic        draw_hit;

	assign draw_row  = {1'b0, vy_q[4:0]} + {2'b0, cnt_q};
	assign draw_mask = {mem_rd_q, 56'b0} >> vx_q[5:0];
	assign draw_hit  = |(f_rd_q & draw_mask);
	assign mem_off   = i_q + {8'b0, cnt_q};

	// Decimal digits of Vx; tens by reciprocal multiply for values below 100.
	logic [1:0]  bcd_h;
	logic [7:0]  bcd_rem;
	logic [14:0] bcd_prod;
	logic [3:0]  bcd_t, bcd_o;

	always_comb begin
		if (vx_q >= 8'd200) begin
			bcd_h   = 2'd2;
			bcd_rem = vx_q - 8'd200;
		end else if (vx_q >= 8'd100) begin
			bcd_h   = 2'd1;
			bcd_rem = vx_q - 8'd100;
		end else begin
			bcd_h   = 2'd0;
			bcd_rem = vx_q;
		end
		bcd_prod = {8'b0, bcd_rem[6:0]} * 15'd205;
		bcd_t    = bcd_prod[14:11];
		bcd_o    = 4'(bcd_rem[6:0] - 7'({3'b0, bcd_t} * 7'd10));
	end

	// ALU for the register-register group.
	logic [8:0] alu_sum;
	logic [7:0] alu_res;
	logic       alu_we, alu_flag;

	always_comb begin
		alu_sum  = {1'b0, vx_q} + {1'b0, vy_q};
		alu_res  = vy_q;
		alu_we   = 1'b1;
		alu_flag = 1'b0;
		case (n)
			ALU_MOV:  alu_res = vy_q;
			ALU_OR:   alu_res = vx_q | vy_q;
			ALU_AND:  alu_res = vx_q & vy_q;
			ALU_XOR:  alu_res = vx_q ^ vy_q;
			ALU_ADD: begin
				alu_res  = alu_sum[7:0];
				alu_flag = alu_sum[8];
			end
			ALU_SUB: begin
				alu_res  = vx_q - vy_q;
				alu_flag = (vx_q > vy_q);
			end
			ALU_SHR: begin
				alu_res  = {1'b0, vy_q[7:1]};
				alu_flag = vy_q[0];
			end
			ALU_SUBN: begin
				alu_res  = vy_q - vx_q;
				alu_flag = (vy_q > vx_q);
			end
			ALU_SHL: begin
				alu_res  = {vy_q[6:0], 1'b0};
				alu_flag = vy_q[7];
			end
			default: alu_we = 1'b0;
		endcase
	end

	// Lowest newly pressed key during a key wait.
	logic [15:0] fresh;
	logic [3:0]  key_idx;

	assign fresh = keys_q & ~base_q;

	always_comb begin
		key_idx = 4'd0;
		for (int k = 15; k >= 0; k--) begin
			if (fresh[k]) key_idx = 4'(k);
		end
	end

	logic       key_down;
	logic [12:0] adi_sum;
	logic [11:0] fnt_addr;

	assign key_down = keys_q[vx_q[3:0]];
	assign adi_sum  = {1'b0, i_q} + {5'b0, vx_q};
	assign fnt_addr = {2'b0, vx_q, 2'b0} + {4'b0, vx_q};

	// Main memory port selection.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = addr_q;
		mem_wd = byte_q;
		mem_ra = pc_q;
		case (cmd)
			CMD_LOAD:    mem_we = 1'b1;
			CMD_FETCH1:  mem_ra = pc_q + 12'd1;
			CMD_DRAW_RD: mem_ra = mem_off;
			CMD_LD_RD:   mem_ra = mem_off;
			CMD_BCD0: begin
				mem_we = 1'b1;
				mem_wa = i_q;
				mem_wd = {6'b0, bcd_h};
			end
			CMD_BCD1: begin
				mem_we = 1'b1;
				mem_wa = i_q + 12'd1;
				mem_wd = {4'b0, bcd_t};
			end
			CMD_BCD2: begin
				mem_we = 1'b1;
				mem_wa = i_q + 12'd2;
				mem_wd = {4'b0, bcd_o};
			end
			CMD_ST_WR: begin
				mem_we = 1'b1;
				mem_wa = mem_off;
				mem_wd = v_rd_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		mem_rd_q <= mem[mem_ra];
	end

	// Data register port selection.
	always_comb begin
		v_ra = x;
		v_we = 1'b0;
		v_wa = x;
		v_wd = alu_res;
		case (cmd)
			CMD_RD_X:  v_ra = y;
			CMD_RD_Y:  v_ra = 4'd0;
			CMD_ST_RD: v_ra = cnt_q;
			CMD_EXEC: begin
				case (opc)
					OPC_LDI: begin
						v_we = 1'b1;
						v_wd = nn;
					end
					OPC_ADDI: begin
						v_we = 1'b1;
						v_wd = vx_q + nn;
					end
					OPC_ALU: v_we = alu_we;
					OPC_RND: begin
						v_we = 1'b1;
						v_wd = rnd_q & nn;
					end
					OPC_MISC: begin
						v_we = (nn == MISC_GDT);
						v_wd = dly_q;
					end
					default: ;
				endcase
			end
			CMD_FLAG: begin
				v_we = 1'b1;
				v_wa = 4'hF;
				v_wd = {7'b0, flag_q};
			end
			CMD_KEY: begin
				v_we = (fresh != 16'd0);
				v_wa = kwreg_q;
				v_wd = {4'b0, key_idx};
			end
			CMD_LD_WR: begin
				v_we = 1'b1;
				v_wa = cnt_q;
				v_wd = mem_rd_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (v_we) vmem[v_wa] <= v_wd;
		v_rd_q <= v_valid_q[v_ra] ? vmem[v_ra] : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_valid_q <= '0;
		end else if (v_we) begin
			v_valid_q[v_wa] <= 1'b1;
		end
	end

	// Return stack: written by calls, read ahead of every instruction.
	assign stk_we = (cmd == CMD_EXEC) && (opc == OPC_CALL) && (lvl_q != LW'(STACK_DEPTH));
	assign stk_ra = SAW'(lvl_q - LW'(1));

	always_ff @(posedge clk) begin
		if (stk_we) stk[lvl_q[SAW-1:0]] <= pc_q;
		stk_rd_q <= stk[stk_ra];
	end

	// Frame port selection.
	assign f_clr = (cmd == CMD_EXEC) && (opc == OPC_SYS) && (nnn == SYS_CLS);
	assign f_we  = (cmd == CMD_DRAW_WR);
	assign f_wa  = draw_row[4:0];
	assign f_wd  = f_rd_q ^ draw_mask;
	assign f_ra  = (cmd == CMD_DRAW_RD) ? draw_row[4:0] : row_q;

	always_ff @(posedge clk) begin
		if (f_we) fmem[f_wa] <= f_wd;
		f_rd_q <= f_valid_q[f_ra] ? fmem[f_ra] : 64'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_valid_q <= '0;
		end else if (f_clr) begin
			f_valid_q <= '0;
		end else if (f_we) begin
			f_valid_q[f_wa] <= 1'b1;
		end
	end

	// Item fields and working registers.
	always_ff @(posedge clk) begin
		case (cmd)
			CMD_ACCEPT: begin
				op_q   <= op_t'(operation);
				addr_q <= load_address;
				byte_q <= load_byte;
				keys_q <= key_bits;
				rnd_q  <= random_byte;
				col_q  <= query_column;
				row_q  <= query_row;
			end
			CMD_FETCH1: hi_q <= mem_rd_q;
			CMD_FETCH2: lo_q <= mem_rd_q;
			CMD_RD_X:   vx_q <= v_rd_q;
			CMD_RD_Y:   vy_q <= v_rd_q;
			CMD_EXEC: begin
				cnt_q <= 4'd0;
				if (opc == OPC_ALU) flag_q <= alu_flag;
				else if (opc == OPC_MISC) flag_q <= adi_sum[12];
				else flag_q <= 1'b0;
			end
			CMD_DRAW_WR: begin
				cnt_q  <= cnt_q + 4'd1;
				flag_q <= flag_q | draw_hit;
			end
			CMD_ST_WR: cnt_q <= cnt_q + 4'd1;
			CMD_LD_WR: cnt_q <= cnt_q + 4'd1;
			default: ;
		endcase
	end

	// Architectural state updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= PC_START;
			i_q       <= 12'd0;
			dly_q     <= 8'd0;
			snd_q     <= 8'd0;
			kw_q      <= 1'b0;
			kwreg_q   <= 4'd0;
			base_q    <= 16'd0;
			lvl_q     <= '0;
			pixel_q   <= 1'b0;
			changed_q <= 1'b0;
			fault_q   <= 1'b0;
		end else begin
			case (cmd)
				CMD_ACCEPT: begin
					pixel_q   <= 1'b0;
					changed_q <= 1'b0;
					fault_q   <= 1'b0;
					if (operation == OP_EXEC) begin
						if (dly_q != 8'd0) dly_q <= dly_q - 8'd1;
						if (snd_q != 8'd0) snd_q <= snd_q - 8'd1;
					end
				end
				CMD_PIX_GET: pixel_q <= f_rd_q[~col_q];
				CMD_FETCH2:  pc_q <= pc_q + 12'd2;
				CMD_EXEC: begin
					case (opc)
						OPC_SYS: begin
							if (nnn == SYS_CLS) begin
								changed_q <= 1'b1;
							end else if (nnn == SYS_RET) begin
								if (lvl_q == '0) begin
									fault_q <= 1'b1;
								end else begin
									lvl_q <= lvl_q - LW'(1);
									pc_q  <= stk_rd_q;
								end
							end
						end
						OPC_JP: pc_q <= nnn;
						OPC_CALL: begin
							if (lvl_q == LW'(STACK_DEPTH)) fault_q <= 1'b1;
							else lvl_q <= lvl_q + LW'(1);
							pc_q <= nnn;
						end
						OPC_SEI:  if (vx_q == nn) pc_q <= pc_q + 12'd2;
						OPC_SNEI: if (vx_q != nn) pc_q <= pc_q + 12'd2;
						OPC_SER:  if (vx_q == vy_q) pc_q <= pc_q + 12'd2;
						OPC_SNER: if (vx_q != vy_q) pc_q <= pc_q + 12'd2;
						OPC_LDIX: i_q <= nnn;
						OPC_JPV0: pc_q <= nnn + {4'b0, v_rd_q};
						OPC_DRW:  changed_q <= 1'b1;
						OPC_KEY: begin
							if ((nn == KEY_DOWN && key_down) || (nn == KEY_UP && !key_down))
								pc_q <= pc_q + 12'd2;
						end
						OPC_MISC: begin
							case (nn)
								MISC_WK: begin
									kw_q    <= 1'b1;
									kwreg_q <= x;
									base_q  <= keys_q;
									pc_q    <= pc_q - 12'd2;
								end
								MISC_SDT: dly_q <= vx_q;
								MISC_SST: snd_q <= vx_q;
								MISC_ADI: i_q <= adi_sum[11:0];
								MISC_FNT: i_q <= fnt_addr;
								default: ;
							endcase
						end
						default: ;
					endcase
				end
				CMD_KEY: begin
					if (fresh != 16'd0) begin
						kw_q <= 1'b0;
						pc_q <= pc_q + 12'd2;
					end else begin
						base_q <= keys_q;
					end
				end
				CMD_ST_WR, CMD_LD_WR: begin
					if (cnt_q == x) i_q <= i_q + {8'b0, x} + 12'd1;
				end
				default: ;
			endcase
		end
	end

	// ALU operations that also write the flag register.
	function automatic logic alu_flag_op(input logic [3:0] sel);
		alu_flag_op = (sel == ALU_ADD) || (sel == ALU_SUB) || (sel == ALU_SHR) ||
		              (sel == ALU_SUBN) || (sel == ALU_SHL);
	endfunction

	// Status towards the controller.
	always_comb begin
		st.op        = op_q;
		st.key_wait  = kw_q;
		st.is_draw   = (opc == OPC_DRW);
		st.is_flag   = ((opc == OPC_ALU) && alu_flag_op(n)) ||
		               ((opc == OPC_MISC) && (nn == MISC_ADI));
		st.is_bcd    = (opc == OPC_MISC) && (nn == MISC_BCD);
		st.is_store  = (opc == OPC_MISC) && (nn == MISC_STR);
		st.is_load   = (opc == OPC_MISC) && (nn == MISC_LDR);
		st.draw_end  = (cnt_q == n) || draw_row[5];
		st.loop_last = (cnt_q == x);
	end

	assign program_counter = pc_q;
	assign pixel_on        = pixel_q;
	assign sound_active    = (snd_q != 8'd0);
	assign frame_changed   = changed_q;
	assign waiting_key     = kw_q;
	assign stack_fault     = fault_q;

	`ASSERT_CLK(a_lvl_range, lvl_q <= LW'(STACK_DEPTH), "stack level beyond depth")
	`ASSERT_NEXT(a_cls_clears, f_clr, f_valid_q == '0, "frame clear left rows valid")
	`ASSERT_NEXT(a_wait_holds, cmd == CMD_KEY && fresh == 16'd0, kw_q && $stable(pc_q),
		"key wait released without a new key")

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import bvm_pkg::*;

	// One command item and one result as seen on the ports.
	typedef struct {
		op_t         op;
		logic [11:0] addr;
		logic [7:0]  ld_val;
		logic [15:0] keys;
		logic [7:0]  rnd;
		logic [5:0]  col;
		logic [4:0]  row;
	} item_t;

	typedef struct {
		logic [11:0] pc;
		logic        pix;
		logic        snd;
		logic        chg;
		logic        wk;
		logic        flt;
	} res_t;

	typedef struct {
		item_t it;
		bit    typed;
		res_t  exp;
	} drow_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  operation = '0;
	logic [11:0] load_address = '0;
	logic [7:0]  load_byte = '0;
	logic [15:0] key_bits = '0;
	logic [7:0]  random_byte = '0;
	logic [5:0]  query_column = '0;
	logic [4:0]  query_row = '0;
	logic        done;
	logic [11:0] program_counter;
	logic        pixel_on;
	logic        sound_active;
	logic        frame_changed;
	logic        waiting_key;
	logic        stack_fault;

	bytecode_vm_core_with_display i_dut (
		.clk, .arst_n, .start, .busy, .operation, .load_address, .load_byte,
		.key_bits, .random_byte, .query_column, .query_row, .done,
		.program_counter, .pixel_on, .sound_active, .frame_changed,
		.waiting_key, .stack_fault
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Shadow copy of the machine state.
	logic [7:0]  mem_img [MEM_BYTES];
	bit          mem_set [MEM_BYTES];
	logic [7:0]  vreg [16];
	logic [11:0] ireg;
	logic [11:0] pcr;
	logic [11:0] ret_stack [STACK_DEPTH_DEF];
	int unsigned depth;
	logic [7:0]  delay_t;
	logic [7:0]  sound_t;
	bit          frame [SCREEN_WIDTH * SCREEN_HEIGHT];
	bit          kwait;
	logic [15:0] kbase;
	logic [3:0]  kreg;

	res_t  results_due [$];
	drow_t dir_rows [$];
	int    fails = 0;
	int    n_sent = 0;
	int    n_exec = 0, n_draw = 0, n_fault = 0, n_wait = 0, n_pix = 0;
	bit    gaps_on = 1'b1;
	bit    call_heavy = 1'b0;

	// Works out the result of one item and advances the shadow state.
	function automatic res_t machine_step(item_t it);
		res_t        r;
		logic [15:0] ins, fresh;
		logic [3:0]  opc, x, y, n;
		logic [7:0]  nn, vx, vy, bits;
		logic [11:0] nnn, a;
		logic [8:0]  s9;
		logic [12:0] s13;
		int          row, col, k;
		bit          hit;
		r = '{default: '0};
		case (it.op)
			OP_LOAD: begin
				mem_img[it.addr] = it.ld_val;
				mem_set[it.addr] = 1'b1;
			end
			OP_PIXEL: r.pix = frame[it.row * SCREEN_WIDTH + it.col];
			OP_EXEC: begin
				if (delay_t != 0) delay_t--;
				if (sound_t != 0) sound_t--;
				if (kwait) begin
					fresh = it.keys & ~kbase;
					if (fresh != 0) begin
						k = 0;
						while (!fresh[k]) k++;
						vreg[kreg] = k[7:0];
						kwait = 1'b0;
						pcr += 12'd2;
					end else begin
						kbase = it.keys;
					end
				end else begin
					a = pcr + 12'd1;
					ins = {mem_img[pcr], mem_img[a]};
					pcr += 12'd2;
					{opc, x, y, n} = ins;
					nn = ins[7:0];
					nnn = ins[11:0];
					vx = vreg[x];
					vy = vreg[y];
					case (opc)
						OPC_SYS: begin
							if (nnn == SYS_CLS) begin
								foreach (frame[i]) frame[i] = 1'b0;
								r.chg = 1'b1;
							end else if (nnn == SYS_RET) begin
								if (depth == 0) r.flt = 1'b1;
								else begin
									depth--;
									pcr = ret_stack[depth];
								end
							end
						end
						OPC_JP: pcr = nnn;
						OPC_CALL: begin
							if (depth >= STACK_DEPTH_DEF) r.flt = 1'b1;
							else begin
								ret_stack[depth] = pcr;
								depth++;
							end
							pcr = nnn;
						end
						OPC_SEI:  if (vx == nn) pcr += 12'd2;
						OPC_SNEI: if (vx != nn) pcr += 12'd2;
						OPC_SER:  if (vx == vy) pcr += 12'd2;
						OPC_LDI:  vreg[x] = nn;
						OPC_ADDI: vreg[x] = vx + nn;
						OPC_ALU: begin
							case (n)
								ALU_MOV: vreg[x] = vy;
								ALU_OR:  vreg[x] = vx | vy;
								ALU_AND: vreg[x] = vx & vy;
								ALU_XOR: vreg[x] = vx ^ vy;
								ALU_ADD: begin
									s9 = vx + vy;
									vreg[x] = s9[7:0];
									vreg[15] = {7'd0, s9[8]};
								end
								ALU_SUB: begin
									vreg[x] = vx - vy;
									vreg[15] = {7'd0, vx > vy};
								end
								ALU_SHR: begin
									vreg[x] = vy >> 1;
									vreg[15] = {7'd0, vy[0]};
								end
								ALU_SUBN: begin
									vreg[x] = vy - vx;
									vreg[15] = {7'd0, vy > vx};
								end
								ALU_SHL: begin
									vreg[x] = vy << 1;
									vreg[15] = {7'd0, vy[7]};
								end
								default: ;
							endcase
						end
						OPC_SNER: if (vx != vy) pcr += 12'd2;
						OPC_LDIX: ireg = nnn;
						OPC_JPV0: pcr = nnn + vreg[0];
						OPC_RND:  vreg[x] = it.rnd & nn;
						OPC_DRW: begin
							// Sprite rows and columns beyond the frame edge are clipped.
							hit = 1'b0;
							for (int j = 0; j < n; j++) begin
								row = vy[4:0] + j;
								if (row >= SCREEN_HEIGHT) break;
								a = ireg + j[11:0];
								bits = mem_img[a];
								for (int b = 0; b < 8; b++) begin
									col = vx[5:0] + b;
									if (col >= SCREEN_WIDTH) break;
									if (bits[7 - b]) begin
										if (frame[row * SCREEN_WIDTH + col]) hit = 1'b1;
										frame[row * SCREEN_WIDTH + col] ^= 1'b1;
									end
								end
							end
							vreg[15] = {7'd0, hit};
							r.chg = 1'b1;
						end
						OPC_KEY: begin
							if (nn == KEY_DOWN && it.keys[vx[3:0]]) pcr += 12'd2;
							else if (nn == KEY_UP && !it.keys[vx[3:0]]) pcr += 12'd2;
						end
						default: begin
							case (nn)
								MISC_GDT: vreg[x] = delay_t;
								MISC_WK: begin
									kwait = 1'b1;
									kreg = x;
									kbase = it.keys;
									pcr -= 12'd2;
								end
								MISC_SDT: delay_t = vx;
								MISC_SST: sound_t = vx;
								MISC_ADI: begin
									s13 = ireg + vx;
									ireg = s13[11:0];
									vreg[15] = {7'd0, s13[12]};
								end
								MISC_FNT: ireg = vx * 12'd5;
								MISC_BCD: begin
									for (int j = 0; j < 3; j++) begin
										a = ireg + j[11:0];
										mem_img[a] = 8'((j == 0) ? vx / 100 :
											(j == 1) ? (vx % 100) / 10 : vx % 10);
										mem_set[a] = 1'b1;
									end
								end
								MISC_STR: begin
									for (int j = 0; j <= x; j++) begin
										a = ireg + j[11:0];
										mem_img[a] = vreg[j];
										mem_set[a] = 1'b1;
									end
									ireg = ireg + x + 12'd1;
								end
								MISC_LDR: begin
									for (int j = 0; j <= x; j++) begin
										a = ireg + j[11:0];
										vreg[j] = mem_img[a];
									end
									ireg = ireg + x + 12'd1;
								end
								default: ;
							endcase
						end
					endcase
				end
			end
			default: ;
		endcase
		r.pc = pcr;
		r.snd = (sound_t != 0);
		r.wk = kwait;
		return r;
	endfunction

	// Random instruction, biased towards calls or returns by phase.
	function automatic logic [15:0] gen_instr();
		logic [3:0]  opc, x, y, n;
		logic [7:0]  nn;
		int          r;
		logic [7:0]  misc_ops [10];
		logic [3:0]  alu_ops [10];
		misc_ops = '{MISC_GDT, MISC_WK, MISC_SDT, MISC_SST, MISC_ADI, MISC_FNT,
			MISC_BCD, MISC_STR, MISC_LDR, 8'h00};
		alu_ops = '{ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SHR,
			ALU_SUBN, ALU_SHL, 4'h0};
		r = $urandom_range(99);
		x = 4'($urandom_range(15));
		y = 4'($urandom_range(15));
		n = 4'($urandom_range(15));
		nn = 8'($urandom_range(255));
		if (r < 20)
			return call_heavy ? {OPC_CALL, 12'($urandom_range(4095))} : {OPC_SYS, SYS_RET};
		opc = 4'($urandom_range(15));
		case (opc)
			OPC_SYS: begin
				r = $urandom_range(2);
				return (r == 0) ? {OPC_SYS, SYS_CLS} : (r == 1) ? {OPC_SYS, SYS_RET} :
					{OPC_SYS, 12'($urandom_range(4095))};
			end
			OPC_ALU: begin
				r = $urandom_range(9);
				return {OPC_ALU, x, y, (r == 9) ? 4'($urandom_range(15)) : alu_ops[r]};
			end
			OPC_KEY: begin
				r = $urandom_range(2);
				return {OPC_KEY, x, (r == 0) ? KEY_DOWN : (r == 1) ? KEY_UP : nn};
			end
			OPC_MISC: begin
				r = $urandom_range(9);
				return {OPC_MISC, x, (r == 9) ? nn : misc_ops[r]};
			end
			default: return {opc, x, y, n};
		endcase
	endfunction

	// Drives one item, waits for it to be taken, and records what it should give.
	task automatic send_item(item_t it, bit typed = 1'b0, res_t typed_res = '{default: '0});
		res_t r;
		if (gaps_on)
			while ($urandom_range(99) < 30) begin
				start = 1'b0;
				@(negedge clk);
			end
		start = 1'b1;
		operation = it.op;
		load_address = it.addr;
		load_byte = it.ld_val;
		key_bits = it.keys;
		random_byte = it.rnd;
		query_column = it.col;
		query_row = it.row;
		do @(posedge clk); while (busy);
		r = machine_step(it);
		results_due = {results_due, (typed ? typed_res : r)};
		n_sent++;
		@(negedge clk);
	endtask

	function automatic item_t rand_item(op_t op);
		item_t it;
		it.op = op;
		it.addr = 12'($urandom_range(4095));
		it.ld_val = 8'($urandom_range(255));
		it.keys = ($urandom_range(99) < 30) ? 16'h0 : 16'($urandom_range(65535));
		it.rnd = 8'($urandom_range(255));
		it.col = 6'($urandom_range(63));
		it.row = 5'($urandom_range(31));
		return it;
	endfunction

	task automatic load_mem(logic [11:0] a, logic [7:0] v);
		item_t it;
		it = rand_item(OP_LOAD);
		it.addr = a;
		it.ld_val = v;
		send_item(it);
	endtask

	// Loads every byte the next instruction will read, so no unwritten byte is read.
	task automatic prepare_exec();
		logic [11:0] a0, a1, a;
		logic [15:0] ins;
		int          cnt;
		if (kwait) return;
		a0 = pcr;
		a1 = pcr + 12'd1;
		if (!mem_set[a0] && !mem_set[a1]) begin
			ins = gen_instr();
			load_mem(a0, ins[15:8]);
			load_mem(a1, ins[7:0]);
		end else if (!mem_set[a0]) begin
			load_mem(a0, 8'($urandom_range(255)));
		end else if (!mem_set[a1]) begin
			load_mem(a1, 8'($urandom_range(255)));
		end
		ins = {mem_img[a0], mem_img[a1]};
		cnt = 0;
		if (ins[15:12] == OPC_DRW) cnt = ins[3:0];
		else if (ins[15:12] == OPC_MISC && ins[7:0] == MISC_LDR) cnt = ins[11:8] + 1;
		for (int k = 0; k < cnt; k++) begin
			a = ireg + k[11:0];
			if (!mem_set[a]) load_mem(a, 8'($urandom_range(255)));
		end
	endtask

	function automatic void add_dir(op_t op, logic [11:0] a, logic [7:0] v, logic [15:0] k,
			logic [5:0] c, logic [4:0] rw, bit t, logic [11:0] pc = '0, bit pix = 1'b0,
			bit chg = 1'b0, bit wk = 1'b0, bit flt = 1'b0);
		drow_t d;
		d.it = '{op: op, addr: a, ld_val: v, keys: k, rnd: 8'hA5, col: c, row: rw};
		d.typed = t;
		d.exp = '{pc: pc, pix: pix, snd: 1'b0, chg: chg, wk: wk, flt: flt};
		dir_rows = {dir_rows, d};
	endfunction

	// Result checker: every strobe is compared with the oldest expectation.
	always @(posedge clk) begin
		res_t e;
		if (arst_n && done) begin
			if (results_due.size() == 0) begin
				$error("unexpected result item, pc %0h", program_counter);
				fails++;
			end else begin
				e = results_due.pop_front();
				if (program_counter !== e.pc) begin
					$error("program_counter: expected %0h, got %0h", e.pc, program_counter);
					fails++;
				end
				if (pixel_on !== e.pix) begin
					$error("pixel_on: expected %0b, got %0b", e.pix, pixel_on);
					fails++;
				end
				if (sound_active !== e.snd) begin
					$error("sound_active: expected %0b, got %0b", e.snd, sound_active);
					fails++;
				end
				if (frame_changed !== e.chg) begin
					$error("frame_changed: expected %0b, got %0b", e.chg, frame_changed);
					fails++;
				end
				if (waiting_key !== e.wk) begin
					$error("waiting_key: expected %0b, got %0b", e.wk, waiting_key);
					fails++;
				end
				if (stack_fault !== e.flt) begin
					$error("stack_fault: expected %0b, got %0b", e.flt, stack_fault);
					fails++;
				end
				n_draw += e.chg;
				n_fault += e.flt;
				n_wait += e.wk;
			end
		end
	end

	// Overall limit on the run.
	initial begin
		#50ms;
		$display("bytecode_vm_core_with_display test failed");
		$finish;
	end

	initial begin
		int   r, settle;
		foreach (mem_set[i]) mem_set[i] = 1'b0;
		foreach (vreg[i]) vreg[i] = '0;
		foreach (frame[i]) frame[i] = 1'b0;
		ireg = '0;
		pcr = PC_START;
		depth = 0;
		delay_t = '0;
		sound_t = '0;
		kwait = 1'b0;
		kbase = '0;
		kreg = '0;

		// Directed part: empty frame, screen clear, return underflow, key wait,
		// jump to the top of memory and wrap of the program counter.
		add_dir(OP_PIXEL, 12'h0, 8'h0, 16'h0, 6'd63, 5'd31, 1'b1, 12'h200);
		add_dir(OP_NOP, 12'hFFF, 8'hFF, 16'hFFFF, 6'd0, 5'd0, 1'b1, 12'h200);
		add_dir(OP_LOAD, 12'h200, 8'h00, 16'h0, 6'd0, 5'd0, 1'b0);
		add_dir(OP_LOAD, 12'h201, 8'hE0, 16'h0, 6'd0, 5'd0, 1'b0);
		add_dir(OP_EXEC, 12'h0, 8'h0, 16'h0, 6'd0, 5'd0, 1'b1, 12'h202, 1'b0, 1'b1);
		add_dir(OP_LOAD, 12'h202, 8'h00, 16'h0, 6'd0, 5'd0, 1'b0);
		add_dir(OP_LOAD, 12'h203, 8'hEE, 16'h0, 6'd0, 5'd0, 1'b0);
		add_dir(OP_EXEC, 12'h0, 8'h0, 16'h0, 6'd0, 5'd0, 1'b1, 12'h204, 1'b0, 1'b0, 1'b0,
			1'b1);
		add_dir(OP_LOAD, 12'h204, 8'hF3, 16'h0, 6'd0, 5'd0, 1'b0);
		add_dir(OP_LOAD, 12'h205, 8'h0A, 16'h0, 6'd0, 5'd0, 1'b0);
		add_dir(OP_EXEC, 12'h0, 8'h0, 16'hFFFF, 6'd0, 5'd0, 1'b1, 12'h204, 1'b0, 1'b0, 1'b1);
		add_dir(OP_EXEC, 12'h0, 8'h0, 16'hFFFF, 6'd0, 5'd0, 1'b1, 12'h204, 1'b0, 1'b0, 1'b1);
		add_dir(OP_EXEC, 12'h0, 8'h0, 16'h0000, 6'd0, 5'd0, 1'b1, 12'h204, 1'b0, 1'b0, 1'b1);
		add_dir(OP_EXEC, 12'h0, 8'h0, 16'h8000, 6'd0, 5'd0, 1'b1, 12'h206);
		add_dir(OP_LOAD, 12'h206, 8'h1F, 16'h0, 6'd0, 5'd0, 1'b0);
		add_dir(OP_LOAD, 12'h207, 8'hFE, 16'h0, 6'd0, 5'd0, 1'b0);
		add_dir(OP_EXEC, 12'h0, 8'h0, 16'h0, 6'd0, 5'd0, 1'b1, 12'hFFE);
		add_dir(OP_LOAD, 12'hFFE, 8'h60, 16'h0, 6'd0, 5'd0, 1'b0);
		add_dir(OP_LOAD, 12'hFFF, 8'hFF, 16'h0, 6'd0, 5'd0, 1'b0);
		add_dir(OP_EXEC, 12'h0, 8'h0, 16'h0, 6'd0, 5'd0, 1'b1, 12'h000);
		add_dir(OP_PIXEL, 12'h0, 8'h0, 16'h0, 6'd0, 5'd0, 1'b1, 12'h000);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].it.op == OP_EXEC) n_exec++;
			send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].exp);
		end

		// Random part: mostly programs executed from lazily loaded memory,
		// with pixel reads, stray loads and no-ops mixed in. The count includes
		// the loads that prepare each instruction.
		for (int i = 0; n_sent < 1150; i++) begin
			gaps_on = !(n_sent >= 500 && n_sent < 700);
			if (i % 50 == 0) call_heavy = 1'($urandom_range(1));
			r = $urandom_range(99);
			if (r < 70) begin
				prepare_exec();
				send_item(rand_item(OP_EXEC));
				n_exec++;
			end else if (r < 84) begin
				send_item(rand_item(OP_PIXEL));
				n_pix++;
			end else if (r < 95) begin
				send_item(rand_item(OP_LOAD));
			end else begin
				send_item(rand_item(OP_NOP));
			end
		end
		start = 1'b0;

		// Drain the outstanding results, then let the bench settle before the summary.
		settle = 0;
		while (results_due.size() != 0 && settle < 2000) begin
			@(posedge clk);
			settle++;
		end
		repeat (60) @(posedge clk);

		$display("Ran %0d instruction steps and %0d pixel reads: %0d frame updates,",
			n_exec, n_pix, n_draw);
		$display("%0d stack faults and %0d results with a key wait pending.", n_fault, n_wait);
		if (fails == 0 && results_due.size() == 0) begin
			$display("bytecode_vm_core_with_display test passed");
		end else begin
			$display("bytecode_vm_core_with_display test failed");
		end
		$finish;
	end

endmodule
